@@ sv/c2d_pkg.sv @@
package c2d_pkg;

	localparam int PIX_W   = 16;  // Q3.12 pixel / coefficient
	localparam int CFG_W   = 16;  // config write data
	localparam int DIM_W   = 7;   // frame size registers
	localparam int COORD_W = 6;   // row / col fields
	localparam int RAW_W   = 8;   // signed tap coordinate, row +/- radius

	typedef enum logic [1:0] {
		KIND_PIXEL   = 2'd0,
		KIND_COEF    = 2'd1,
		KIND_COMPUTE = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		BORDER_CONST      = 2'd0,
		BORDER_REPLICATE  = 2'd1,
		BORDER_REFLECT    = 2'd2,
		BORDER_REFLECT101 = 2'd3
	} border_t;

	typedef enum logic [2:0] {
		REG_FRAME_WIDTH   = 3'd0,
		REG_FRAME_HEIGHT  = 3'd1,
		REG_KERNEL_RADIUS = 3'd2,
		REG_BORDER_MODE   = 3'd3,
		REG_BORDER_VALUE  = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		kind_t                     kind;
		logic [COORD_W-1:0]        row;
		logic [COORD_W-1:0]        col;
		logic signed [PIX_W-1:0]   value;
	} in_word_t;

	typedef struct packed {
		logic signed [PIX_W-1:0]   pixel_out;
		logic                      saturated;
	} out_word_t;

	// control from the tap sequencer to the MAC
	typedef struct packed {
		logic clear;  // start of a new output pixel
		logic tap;    // coef / pix valid this cycle
	} mac_ctl_t;

endpackage

@@ sv/c2d_mac.sv @@
module c2d_mac
	import c2d_pkg::*;
#(
	parameter int ACC_W = 41
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  mac_ctl_t                ctl,
	input  logic signed [PIX_W-1:0] coef,
	input  logic signed [PIX_W-1:0] pix,
	output logic                    busy,
	output out_word_t               result
);

	localparam int PROD_W = 2 * PIX_W;

	logic signed [PROD_W-1:0] prod_s2;
	logic                     v_s2;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  rnd;
	logic [ACC_W-28:0]        hi;
	logic                     sat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= ctl.tap;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= coef * pix;
		if (ctl.clear) begin
			acc_q <= '0;
		end else if (v_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
	end

	// round half up, floor by 2^12, then clip to 16 bits
	always_comb begin
		rnd = acc_q + ACC_W'(2048);
		hi  = rnd[ACC_W-1:27];
		sat = !((&hi) || (~|hi));
		result.saturated = sat;
		if (sat) begin
			result.pixel_out = rnd[ACC_W-1] ? 16'sh8000 : 16'sh7fff;
		end else begin
			result.pixel_out = rnd[27:12];
		end
	end

	assign busy = v_s2;

endmodule

@@ sv/conv2d_border_modes.sv @@
// Channel  Dir  Handshake            Payload
// in       in   in_valid / in_ready  in_data   (in_word_t: kind, row, col, value)
// out      out  out_valid / out_ready out_data (out_word_t: pixel_out, saturated)
// cfg      in   cfg_we               cfg_index, cfg_data
//
// A compute word runs the shared restoring modulo unit over the row and then
// the column (one numerator bit per step), then r back-steps of the border
// walkers, then one tap per cycle through the single frame read port and the
// one multiplier. Reset clears control and config; frame and kernel memories
// hold garbage until written. The finished result sits in the output register,
// so writes and the next compute proceed while out_ready is low; a compute
// only stalls at its very end until the output register is free.
module conv2d_border_modes
	import c2d_pkg::*;
#(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64,
	parameter int MAX_RADIUS = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  in_word_t         in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output out_word_t        out_data,
	input  logic             cfg_we,
	input  cfg_idx_t         cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	localparam int KSIDE  = 2 * MAX_RADIUS + 1;
	localparam int KTAPS  = KSIDE * KSIDE;
	localparam int KAW    = $clog2(KTAPS);
	localparam int FDEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int FAW    = $clog2(FDEPTH);
	localparam int TW     = $clog2(KSIDE);
	localparam int RW     = $clog2(MAX_RADIUS + 1);
	localparam int ACC_W  = 2 * PIX_W + $clog2(KTAPS) + 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MOD_ROW,
		ST_MOD_COL,
		ST_BACK,
		ST_TAPS,
		ST_DRAIN
	} state_t;

	// position of a border walker: folded index and which half of the
	// reflect period the raw coordinate sits in
	typedef struct packed {
		logic [DIM_W-1:0] p;
		logic             up;
	} walk_t;

	// ---------------- config registers ----------------
	logic [DIM_W-1:0]        frame_width_q;
	logic [DIM_W-1:0]        frame_height_q;
	logic [1:0]              kernel_radius_q;
	border_t                 border_mode_q;
	logic signed [PIX_W-1:0] border_value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q   <= DIM_W'(64);
			frame_height_q  <= DIM_W'(64);
			kernel_radius_q <= 2'd1;
			border_mode_q   <= BORDER_CONST;
			border_value_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FRAME_WIDTH:   frame_width_q   <= cfg_data[DIM_W-1:0];
				REG_FRAME_HEIGHT:  frame_height_q  <= cfg_data[DIM_W-1:0];
				REG_KERNEL_RADIUS: kernel_radius_q <= cfg_data[1:0];
				REG_BORDER_MODE:   border_mode_q   <= border_t'(cfg_data[1:0]);
				REG_BORDER_VALUE:  border_value_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---------------- walker helpers ----------------
	function automatic walk_t walk_fwd(walk_t s, logic [DIM_W-1:0] n, logic m101);
		walk_t o;
		o = s;
		if (m101 && n == DIM_W'(1)) begin
			o.p  = '0;
			o.up = 1'b1;
		end else if (s.up) begin
			if (s.p == n - DIM_W'(1)) begin
				if (!m101) begin
					o.up = 1'b0;
				end else if (n == DIM_W'(2)) begin
					o.p = '0;
				end else begin
					o.p  = n - DIM_W'(2);
					o.up = 1'b0;
				end
			end else begin
				o.p = s.p + DIM_W'(1);
			end
		end else begin
			if (m101 && s.p == DIM_W'(1)) begin
				o.p  = '0;
				o.up = 1'b1;
			end else if (!m101 && s.p == '0) begin
				o.up = 1'b1;
			end else begin
				o.p = s.p - DIM_W'(1);
			end
		end
		return o;
	endfunction

	function automatic walk_t walk_bwd(walk_t s, logic [DIM_W-1:0] n, logic m101);
		walk_t o;
		o = s;
		if (m101 && n == DIM_W'(1)) begin
			o.p  = '0;
			o.up = 1'b1;
		end else if (s.up) begin
			if (s.p == '0) begin
				if (!m101) begin
					o.up = 1'b0;
				end else begin
					o.p  = DIM_W'(1);
					o.up = (n == DIM_W'(2));
				end
			end else begin
				o.p = s.p - DIM_W'(1);
			end
		end else begin
			if (m101 && s.p == n - DIM_W'(2)) begin
				o.p  = n - DIM_W'(1);
				o.up = 1'b1;
			end else if (!m101 && s.p == n - DIM_W'(1)) begin
				o.up = 1'b1;
			end else begin
				o.p = s.p + DIM_W'(1);
			end
		end
		return o;
	endfunction

	// fold a remainder within one period into a walker position
	function automatic walk_t walk_init(logic [7:0] q, logic [DIM_W-1:0] n, logic m101);
		walk_t      o;
		logic [7:0] d;
		d = {n, 1'b0} - q - (m101 ? 8'd2 : 8'd1);
		if (m101 && n == DIM_W'(1)) begin
			o.p  = '0;
			o.up = 1'b1;
		end else if (q < {1'b0, n}) begin
			o.p  = q[DIM_W-1:0];
			o.up = 1'b1;
		end else begin
			o.p  = d[DIM_W-1:0];
			o.up = 1'b0;
		end
		return o;
	endfunction

	function automatic logic [7:0] period(logic [DIM_W-1:0] n, logic m101);
		return (m101 && n != DIM_W'(1)) ? ({n, 1'b0} - 8'd2) : {n, 1'b0};
	endfunction

	function automatic logic in_range(logic signed [RAW_W-1:0] c, logic [DIM_W-1:0] n);
		return (c >= 0) && (c < $signed({1'b0, n}));
	endfunction

	function automatic logic [DIM_W-1:0] tap_index(logic signed [RAW_W-1:0] c,
			logic [DIM_W-1:0] n, walk_t w, logic repl);
		logic [DIM_W-1:0] cl;
		if (c < 0) begin
			cl = '0;
		end else if (c >= $signed({1'b0, n})) begin
			cl = n - DIM_W'(1);
		end else begin
			cl = c[DIM_W-1:0];
		end
		return repl ? cl : w.p;
	endfunction

	// ---------------- effective settings ----------------
	logic [DIM_W-1:0] hn;
	logic [DIM_W-1:0] wn;
	logic [RW-1:0]    rad;
	logic [TW-1:0]    span;
	logic             m101;
	logic             repl;
	logic [KAW-1:0]   k_start;

	always_comb begin
		if (frame_height_q == '0) begin
			hn = DIM_W'(1);
		end else if (32'(frame_height_q) > MAX_HEIGHT) begin
			hn = DIM_W'(MAX_HEIGHT);
		end else begin
			hn = frame_height_q;
		end
		if (frame_width_q == '0) begin
			wn = DIM_W'(1);
		end else if (32'(frame_width_q) > MAX_WIDTH) begin
			wn = DIM_W'(MAX_WIDTH);
		end else begin
			wn = frame_width_q;
		end
		rad     = (32'(kernel_radius_q) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(kernel_radius_q);
		span    = TW'({rad, 1'b0});
		m101    = (border_mode_q == BORDER_REFLECT101);
		repl    = (border_mode_q == BORDER_REPLICATE);
		k_start = KAW'(span) * KAW'(KSIDE) + KAW'(span);
	end

	// ---------------- sequencer ----------------
	state_t                   state_q;
	logic [COORD_W-1:0]       mnum_q;    // modulo numerator, shifted out MSB first
	logic [7:0]               mrem_q;
	logic [2:0]               mcnt_q;
	logic [COORD_W-1:0]       col_q;
	logic [RW-1:0]            bcnt_q;
	logic [TW-1:0]            ty_q;
	logic [TW-1:0]            tx_q;
	logic [KAW-1:0]           ki_q;
	logic signed [RAW_W-1:0]  ry_q;
	logic signed [RAW_W-1:0]  rx_q;
	logic signed [RAW_W-1:0]  rx0_q;     // raw column at the left of each kernel row
	walk_t                    wy_q;
	walk_t                    wx_q;
	walk_t                    wx0_q;
	logic                     tap_s1;
	logic                     border_s1;
	logic                     out_valid_q;
	out_word_t                out_q;

	logic [8:0]               mtrial;
	logic [7:0]               mper;
	logic [7:0]               mrem_next;
	logic                     in_acc;
	logic                     busy;
	logic                     out_load;
	out_word_t                mac_res;
	logic [DIM_W-1:0]         yi;
	logic [DIM_W-1:0]         xi;
	logic                     tap_border;
	logic [FAW-1:0]           rd_addr;
	walk_t                    wx0_b;

	assign in_ready = (state_q == ST_IDLE);
	assign in_acc   = in_valid && in_ready;
	// last product lands in the accumulator before this fires
	assign out_load = (state_q == ST_DRAIN) && !tap_s1 && !busy &&
		(!out_valid_q || out_ready);

	always_comb begin
		mper   = (state_q == ST_MOD_COL) ? period(wn, m101) : period(hn, m101);
		mtrial = {mrem_q, mnum_q[COORD_W-1]};
		if (mtrial >= {1'b0, mper}) begin
			mrem_next = 8'(mtrial - {1'b0, mper});
		end else begin
			mrem_next = mtrial[7:0];
		end
		yi         = tap_index(ry_q, hn, wy_q, repl);
		xi         = tap_index(rx_q, wn, wx_q, repl);
		tap_border = (border_mode_q == BORDER_CONST) &&
			!(in_range(ry_q, hn) && in_range(rx_q, wn));
		rd_addr    = FAW'(yi) * FAW'(MAX_WIDTH) + FAW'(xi);
		wx0_b      = walk_bwd(wx0_q, wn, m101);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			out_q       <= '0;
			tap_s1      <= 1'b0;
		end else begin
			tap_s1 <= (state_q == ST_TAPS);
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc && in_data.kind == KIND_COMPUTE) begin
						state_q <= ST_MOD_ROW;
					end
				end
				ST_MOD_ROW: begin
					if (mcnt_q == '0) begin
						state_q <= ST_MOD_COL;
					end
				end
				ST_MOD_COL: begin
					if (mcnt_q == '0) begin
						state_q <= (rad == '0) ? ST_TAPS : ST_BACK;
					end
				end
				ST_BACK: begin
					if (bcnt_q == RW'(1)) begin
						state_q <= ST_TAPS;
					end
				end
				ST_TAPS: begin
					if (tx_q == span && ty_q == span) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (out_load) begin
						out_q   <= mac_res;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers of the sequencer
	always_ff @(posedge clk) begin
		border_s1 <= tap_border;
		case (state_q)
			ST_IDLE: begin
				mnum_q <= in_data.row;
				col_q  <= in_data.col;
				mrem_q <= '0;
				mcnt_q <= 3'(COORD_W - 1);
				ry_q   <= RAW_W'(in_data.row);
				rx_q   <= RAW_W'(in_data.col);
				rx0_q  <= RAW_W'(in_data.col);
				bcnt_q <= rad;
				ty_q   <= '0;
				tx_q   <= '0;
				ki_q   <= k_start;
			end
			ST_MOD_ROW: begin
				if (mcnt_q == '0) begin
					wy_q   <= walk_init(mrem_next, hn, m101);
					mnum_q <= col_q;
					mrem_q <= '0;
					mcnt_q <= 3'(COORD_W - 1);
				end else begin
					mnum_q <= mnum_q << 1;
					mrem_q <= mrem_next;
					mcnt_q <= mcnt_q - 3'd1;
				end
			end
			ST_MOD_COL: begin
				mnum_q <= mnum_q << 1;
				mrem_q <= mrem_next;
				mcnt_q <= mcnt_q - 3'd1;
				if (mcnt_q == '0) begin
					wx_q  <= walk_init(mrem_next, wn, m101);
					wx0_q <= walk_init(mrem_next, wn, m101);
				end
			end
			ST_BACK: begin
				// walk both axes back to the top-left tap
				wy_q   <= walk_bwd(wy_q, hn, m101);
				ry_q   <= ry_q - RAW_W'(1);
				wx0_q  <= wx0_b;
				wx_q   <= wx0_b;
				rx0_q  <= rx0_q - RAW_W'(1);
				rx_q   <= rx0_q - RAW_W'(1);
				bcnt_q <= bcnt_q - RW'(1);
			end
			ST_TAPS: begin
				if (tx_q == span) begin
					tx_q <= '0;
					ty_q <= ty_q + TW'(1);
					wy_q <= walk_fwd(wy_q, hn, m101);
					ry_q <= ry_q + RAW_W'(1);
					wx_q <= wx0_q;
					rx_q <= rx0_q;
					ki_q <= ki_q - KAW'(KSIDE) + KAW'(span);
				end else begin
					tx_q <= tx_q + TW'(1);
					wx_q <= walk_fwd(wx_q, wn, m101);
					rx_q <= rx_q + RAW_W'(1);
					ki_q <= ki_q - KAW'(1);
				end
			end
			default: ;
		endcase
	end

	// ---------------- stores ----------------
	logic signed [PIX_W-1:0] fmem [FDEPTH];
	logic signed [PIX_W-1:0] kmem [KTAPS];
	logic signed [PIX_W-1:0] fdata_s1;
	logic signed [PIX_W-1:0] kdata_s1;
	logic                    fwr;
	logic                    kwr;
	logic [FAW-1:0]          fwr_addr;
	logic [KAW-1:0]          kwr_addr;

	always_comb begin
		fwr      = in_acc && in_data.kind == KIND_PIXEL &&
			32'(in_data.row) < MAX_HEIGHT && 32'(in_data.col) < MAX_WIDTH;
		kwr      = in_acc && in_data.kind == KIND_COEF &&
			32'(in_data.row) < KSIDE && 32'(in_data.col) < KSIDE;
		fwr_addr = FAW'(in_data.row) * FAW'(MAX_WIDTH) + FAW'(in_data.col);
		kwr_addr = KAW'(in_data.row) * KAW'(KSIDE) + KAW'(in_data.col);
	end

	always_ff @(posedge clk) begin
		if (fwr) begin
			fmem[fwr_addr] <= in_data.value;
		end
		fdata_s1 <= fmem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (kwr) begin
			kmem[kwr_addr] <= in_data.value;
		end
		kdata_s1 <= kmem[ki_q];
	end

	// ---------------- multiply-accumulate ----------------
	mac_ctl_t                mac_ctl;
	logic signed [PIX_W-1:0] mac_pix;

	assign mac_ctl.clear = in_acc;
	assign mac_ctl.tap   = tap_s1;
	assign mac_pix       = border_s1 ? border_value_q : fdata_s1;

	c2d_mac #(
		.ACC_W(ACC_W)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.coef   (kdata_s1),
		.pix    (mac_pix),
		.busy   (busy),
		.result (mac_res)
	);

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

@@ test/conv2d_border_modes_tb.sv @@
`timescale 1ns / 100ps

module conv2d_border_modes_tb;
	import c2d_pkg::*;

	localparam int FRAME_DIM   = 64;
	localparam int KSIDE       = 5;
	localparam int MAX_R       = 2;
	localparam int SETTLE_CYC  = 64;
	localparam int ITEM_TARGET = 1150;

	// kind 3 has no enum member; the block must drop it
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	typedef enum logic [1:0] {
		PACE_FULL,   // no gaps, no stalls
		PACE_MIXED,  // short bursts, random ready pattern
		PACE_SLOW    // long gaps, sparse ready, long stalls
	} pace_t;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             in_valid  = 1'b0;
	logic             in_ready;
	in_word_t         in_data   = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	out_word_t        out_data;
	logic             cfg_we    = 1'b0;
	cfg_idx_t         cfg_index = REG_FRAME_WIDTH;
	logic [CFG_W-1:0] cfg_data  = '0;

	conv2d_border_modes i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// ---------------------------------------------------------------
	// Shadow of the block: frame and kernel stores with written marks,
	// and the config registers as last written.
	// ---------------------------------------------------------------
	logic signed [PIX_W-1:0] frame_mem [FRAME_DIM*FRAME_DIM];
	bit                      frame_set [FRAME_DIM*FRAME_DIM];
	logic signed [PIX_W-1:0] coef_mem  [KSIDE*KSIDE];
	bit                      coef_set  [KSIDE*KSIDE];

	logic [DIM_W-1:0]        width_reg      = 7'd64;
	logic [DIM_W-1:0]        height_reg     = 7'd64;
	logic [1:0]              radius_reg     = 2'd1;
	border_t                 mode_reg       = BORDER_CONST;
	logic signed [PIX_W-1:0] border_val_reg = '0;

	out_word_t pending_pixels[$];

	int n_items    = 0;
	int n_checked  = 0;
	int n_sat      = 0;
	int n_settings = 0;
	int n_errors   = 0;

	// sender / receiver pacing
	int          burst_left = 0;
	int          burst_max  = 1;
	int          gap_max    = 0;
	logic [15:0] ready_pat  = 16'hFFFF;
	logic [3:0]  pat_pos    = '0;
	bit          long_stalls = 1'b0;
	int          stall_left = 0;

	function automatic int clamp_dim(logic [DIM_W-1:0] v);
		if (v < 1)
			return 1;
		if (v > FRAME_DIM)
			return FRAME_DIM;
		return int'(v);
	endfunction

	function automatic int used_radius();
		return (radius_reg > MAX_R) ? MAX_R : int'(radius_reg);
	endfunction

	// fold a coordinate back into 0..n-1 (replicate / reflect / reflect101)
	function automatic int fold_coord(int c, int n, border_t m);
		int p;
		case (m)
		BORDER_REPLICATE: begin
			return c < 0 ? 0 : (c > n - 1 ? n - 1 : c);
		end
		BORDER_REFLECT: begin
			p = ((c % (2 * n)) + 2 * n) % (2 * n);
			return p >= n ? 2 * n - 1 - p : p;
		end
		default: begin
			// reflect101 on a single row/col maps everything to 0
			if (n < 2)
				return 0;
			p = ((c % (2 * n - 2)) + 2 * n - 2) % (2 * n - 2);
			return p >= n ? 2 * n - 2 - p : p;
		end
		endcase
	endfunction

	// 1 if the tap reads the frame store (addr set), 0 if it takes border_value
	function automatic bit tap_source(int row, int col, int dy, int dx, output int addr);
		int y, x, w, h;
		w = clamp_dim(width_reg);
		h = clamp_dim(height_reg);
		y = row + dy;
		x = col + dx;
		addr = 0;
		if (y >= 0 && y < h && x >= 0 && x < w) begin
			addr = y * FRAME_DIM + x;
			return 1'b1;
		end
		if (mode_reg == BORDER_CONST)
			return 1'b0;
		addr = fold_coord(y, h, mode_reg) * FRAME_DIM + fold_coord(x, w, mode_reg);
		return 1'b1;
	endfunction

	// true convolution: kernel rotated 180 deg, exact Q6.24 sum, round, saturate
	function automatic out_word_t conv_pixel(int row, int col);
		longint    acc;
		longint    q;
		int        r, addr, cv, pv;
		out_word_t res;
		acc = 0;
		r   = used_radius();
		for (int dy = -r; dy <= r; dy++) begin
			for (int dx = -r; dx <= r; dx++) begin
				if (tap_source(row, col, dy, dx, addr))
					pv = frame_mem[addr];
				else
					pv = border_val_reg;
				cv  = coef_mem[(r - dy) * KSIDE + (r - dx)];
				acc += longint'(cv) * longint'(pv);
			end
		end
		q = (acc + 2048) >>> 12;
		res.saturated = 1'b0;
		if (q > 32767) begin
			res.pixel_out = 16'sh7FFF;
			res.saturated = 1'b1;
		end else if (q < -32768) begin
			res.pixel_out = 16'sh8000;
			res.saturated = 1'b1;
		end else begin
			res.pixel_out = q[PIX_W-1:0];
		end
		return res;
	endfunction

	// shadow update for one accepted word
	function automatic void apply_word(in_word_t w);
		int idx;
		case (w.kind)
		KIND_PIXEL: begin
			idx = int'(w.row) * FRAME_DIM + int'(w.col);
			frame_mem[idx] = w.value;
			frame_set[idx] = 1'b1;
			n_items++;
		end
		KIND_COEF: begin
			// out-of-range kernel coordinates are dropped
			if (w.row < KSIDE && w.col < KSIDE) begin
				idx = int'(w.row) * KSIDE + int'(w.col);
				coef_mem[idx] = w.value;
				coef_set[idx] = 1'b1;
				n_items++;
			end
		end
		KIND_COMPUTE: begin
			pending_pixels.push_back(conv_pixel(int'(w.row), int'(w.col)));
			n_items++;
		end
		default: ;
		endcase
	endfunction

	function automatic in_word_t make_word(kind_t k, int row, int col,
			logic signed [PIX_W-1:0] v);
		in_word_t w;
		w.kind  = k;
		w.row   = COORD_W'(row);
		w.col   = COORD_W'(col);
		w.value = v;
		return w;
	endfunction

	// Q3.12 sample: extremes, values within +/-1.0, or anything
	function automatic logic signed [PIX_W-1:0] rand_q312();
		case ($urandom_range(0, 9))
		0: return 16'sh7FFF;
		1: return 16'sh8000;
		2: return 16'sh0000;
		3: return -16'sh0001;
		4, 5, 6: return PIX_W'($urandom_range(0, 8191) - 4096);
		default: return PIX_W'($urandom);
		endcase
	endfunction

	// ---------------------------------------------------------------
	// Drivers
	// ---------------------------------------------------------------

	// One word on the input channel, sent in bursts with random gaps.
	task automatic send_word(in_word_t w);
		int gap;
		@(negedge clk);
		if (burst_left == 0) begin
			gap = $urandom_range(0, gap_max);
			if (gap > 0) begin
				in_valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, burst_max);
		end
		in_valid = 1'b1;
		in_data  = w;
		do @(posedge clk); while (!in_ready);
		burst_left--;
		apply_word(w);
	endtask

	// Wait until every expected result is back, then let the block settle
	// (trailing writes produce no result).
	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic set_reg(cfg_idx_t idx, logic [CFG_W-1:0] data);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
		REG_FRAME_WIDTH:   width_reg      = data[DIM_W-1:0];
		REG_FRAME_HEIGHT:  height_reg     = data[DIM_W-1:0];
		REG_KERNEL_RADIUS: radius_reg     = data[1:0];
		REG_BORDER_MODE:   mode_reg       = border_t'(data[1:0]);
		REG_BORDER_VALUE:  border_val_reg = data;
		default: ;
		endcase
	endtask

	task automatic configure(int w, int h, int r, border_t m, logic signed [PIX_W-1:0] bv);
		set_reg(REG_FRAME_WIDTH, CFG_W'(w));
		set_reg(REG_FRAME_HEIGHT, CFG_W'(h));
		set_reg(REG_KERNEL_RADIUS, CFG_W'(r));
		set_reg(REG_BORDER_MODE, CFG_W'(m));
		set_reg(REG_BORDER_VALUE, bv);
		n_settings++;
	endtask

	task automatic set_pace(pace_t p);
		case (p)
		PACE_FULL: begin
			gap_max     = 0;
			burst_max   = 1;
			ready_pat   = 16'hFFFF;
			long_stalls = 1'b0;
		end
		PACE_MIXED: begin
			gap_max     = $urandom_range(1, 6);
			burst_max   = $urandom_range(1, 24);
			ready_pat   = 16'($urandom) | 16'h0001;
			long_stalls = 1'b1;
		end
		default: begin
			gap_max     = $urandom_range(8, 20);
			burst_max   = $urandom_range(1, 4);
			ready_pat   = 16'($urandom & $urandom) | 16'h0001;
			long_stalls = 1'b1;
		end
		endcase
	endtask

	// Compute request; any tap pixel or coefficient not yet written gets a
	// random write first so nothing undefined is ever read.
	task automatic compute_at(int row, int col);
		int r, addr;
		r = used_radius();
		for (int dy = -r; dy <= r; dy++) begin
			for (int dx = -r; dx <= r; dx++) begin
				if (tap_source(row, col, dy, dx, addr) && !frame_set[addr])
					send_word(make_word(KIND_PIXEL, addr / FRAME_DIM, addr % FRAME_DIM,
						rand_q312()));
			end
		end
		for (int i = 0; i <= 2 * r; i++) begin
			for (int j = 0; j <= 2 * r; j++) begin
				if (!coef_set[i * KSIDE + j])
					send_word(make_word(KIND_COEF, i, j, rand_q312()));
			end
		end
		send_word(make_word(KIND_COMPUTE, row, col, PIX_W'($urandom)));
	endtask

	// Receiver: ready follows a 16-bit pattern, with occasional long stalls.
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if (long_stalls && $urandom_range(0, 99) == 0) begin
			stall_left = $urandom_range(8, 40);
			out_ready <= 1'b0;
		end else begin
			out_ready <= ready_pat[pat_pos];
			pat_pos   <= pat_pos + 4'd1;
		end
	end

	// ---------------------------------------------------------------
	// Result check
	// ---------------------------------------------------------------
	task automatic flag_error(string msg);
		n_errors++;
		if (n_errors <= 10)
			$display("%0t ns: %s", $time, msg);
	endtask

	out_word_t head_pixel;

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_pixels.size() == 0) begin
				flag_error($sformatf("unexpected word: pixel_out %0d saturated %0b",
					out_data.pixel_out, out_data.saturated));
			end else begin
				head_pixel = pending_pixels.pop_front();
				n_checked++;
				if (head_pixel.saturated)
					n_sat++;
				if (out_data.pixel_out !== head_pixel.pixel_out)
					flag_error($sformatf("pixel_out: expected %0d, got %0d",
						head_pixel.pixel_out, out_data.pixel_out));
				if (out_data.saturated !== head_pixel.saturated)
					flag_error($sformatf("saturated: expected %0b, got %0b",
						head_pixel.saturated, out_data.saturated));
			end
		end
	end

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------

	// Reset config (64x64, 3x3, constant zero border): saturation both ways,
	// unused kind, out-of-range coefficient writes.
	task automatic test_defaults();
		set_pace(PACE_FULL);
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				send_word(make_word(KIND_COEF, i, j, 16'sh7FFF));
		send_word(make_word(KIND_PIXEL, 0, 0, 16'sh7FFF));
		send_word(make_word(KIND_PIXEL, 0, 1, 16'sh7FFF));
		send_word(make_word(KIND_PIXEL, 1, 0, 16'sh7FFF));
		send_word(make_word(KIND_PIXEL, 1, 1, 16'sh7FFF));
		compute_at(0, 0);                      // clips high
		send_word(make_word(KIND_PIXEL, 62, 62, 16'sh8000));
		send_word(make_word(KIND_PIXEL, 62, 63, 16'sh8000));
		send_word(make_word(KIND_PIXEL, 63, 62, 16'sh8000));
		send_word(make_word(KIND_PIXEL, 63, 63, 16'sh8000));
		compute_at(63, 63);                    // clips low
		send_word(make_word(kind_t'(KIND_UNUSED), 0, 0, 16'sh1234));
		send_word(make_word(KIND_COEF, 5, 0, 16'sh0000));
		send_word(make_word(KIND_COEF, 0, 63, 16'sh0000));
		compute_at(1, 1);                      // kernel must be untouched
		compute_at(32, 32);
	endtask

	// Every border mode across size and radius extremes, with centres at the
	// corners, beyond the frame, and far outside it.
	task automatic test_border_modes();
		int      w_list [5] = '{1, 2, 64, 5, 0};
		int      h_list [5] = '{1, 3, 64, 1, 127};
		int      k, w, h;
		border_t bm;
		logic signed [PIX_W-1:0] bv;
		k  = 0;
		bm = BORDER_CONST;
		do begin
			for (int s = 0; s < 5; s++) begin
				drain();
				case (k % 4)
				0: bv = 16'sh7FFF;
				1: bv = 16'sh8000;
				2: bv = 16'sh0000;
				default: bv = rand_q312();
				endcase
				configure(w_list[s], h_list[s], k % 4, bm, bv);
				set_pace(pace_t'(k % 3));
				w = clamp_dim(width_reg);
				h = clamp_dim(height_reg);
				compute_at(0, 0);
				compute_at(h - 1, w - 1);
				compute_at(63, 63);
				compute_at(0, 63);
				compute_at($urandom_range(0, 63), $urandom_range(0, 63));
				k++;
			end
			bm = bm.next();
		end while (bm != BORDER_CONST);
	endtask

	// Random settings, mostly small frames; the stream is mostly writes and
	// computes near the frame with a little noise.
	task automatic test_random();
		int w, h, sel, row, col;
		while (n_items < ITEM_TARGET) begin
			drain();
			case ($urandom_range(0, 9))
			0: w = 64;
			1, 2: w = $urandom_range(13, 63);
			default: w = $urandom_range(1, 12);
			endcase
			case ($urandom_range(0, 9))
			0: h = 64;
			1, 2: h = $urandom_range(13, 63);
			default: h = $urandom_range(1, 12);
			endcase
			configure(w, h, $urandom_range(0, 3), border_t'($urandom_range(0, 3)),
				rand_q312());
			set_pace(pace_t'($urandom_range(0, 2)));
			repeat (120) begin
				sel = $urandom_range(0, 99);
				if (sel < 45) begin
					if ($urandom_range(0, 4) == 0) begin
						row = $urandom_range(0, 63);
						col = $urandom_range(0, 63);
					end else begin
						row = $urandom_range(0, (h + 1 > 63) ? 63 : h + 1);
						col = $urandom_range(0, (w + 1 > 63) ? 63 : w + 1);
					end
					compute_at(row, col);
				end else if (sel < 75) begin
					if ($urandom_range(0, 4) == 0) begin
						row = $urandom_range(0, 63);
						col = $urandom_range(0, 63);
					end else begin
						row = $urandom_range(0, h - 1);
						col = $urandom_range(0, w - 1);
					end
					send_word(make_word(KIND_PIXEL, row, col, rand_q312()));
				end else if (sel < 90) begin
					send_word(make_word(KIND_COEF, $urandom_range(0, KSIDE - 1),
						$urandom_range(0, KSIDE - 1), rand_q312()));
				end else if (sel < 95) begin
					send_word(make_word(kind_t'(KIND_UNUSED), $urandom_range(0, 63),
						$urandom_range(0, 63), PIX_W'($urandom)));
				end else if ($urandom_range(0, 1) == 0) begin
					send_word(make_word(KIND_COEF, $urandom_range(KSIDE, 63),
						$urandom_range(0, 63), PIX_W'($urandom)));
				end else begin
					send_word(make_word(KIND_COEF, $urandom_range(0, KSIDE - 1),
						$urandom_range(KSIDE, 63), PIX_W'($urandom)));
				end
			end
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_defaults();
		test_border_modes();
		test_random();
		drain();

		$display("summary: %0d words applied, %0d config settings", n_items, n_settings);
		$display("summary: %0d output pixels checked, %0d of them clipped, %0d mismatches",
			n_checked, n_sat, n_errors);
		if (n_errors == 0 && pending_pixels.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// run limit: far above the slowest legal run
	initial begin
		#10ms;
		$display("timeout: %0d results still outstanding", pending_pixels.size());
		$display("tb: failure");
		$finish;
	end

endmodule
